>>> design/scr_pkg.sv
`default_nettype none
package scr_pkg;

	localparam int VALUE_W       = 16;
	localparam int CHANNEL_BITS  = 8;
	localparam int FRACTION_BITS = 16;
	localparam int COLOR_W       = 3 * CHANNEL_BITS;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = COLOR_W;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_STOP_MODE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_START = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MID   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_END   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = CFG_IDX_W'(5);

	localparam logic [CHANNEL_BITS-1:0] CH_HALF = CHANNEL_BITS'(1) << (CHANNEL_BITS - 1);
	localparam logic [COLOR_W-1:0] MID_RESET = {3{CH_HALF}};
	localparam logic [COLOR_W-1:0] END_RESET = {COLOR_W{1'b1}};
	localparam logic [VALUE_W-1:0] HIGH_RESET = VALUE_W'(32767);

	typedef enum logic [1:0] {
		CLS_BELOW,
		CLS_ABOVE,
		CLS_INSIDE
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic [VALUE_W-1:0] off;
		logic [VALUE_W-1:0] span;
	} entry_t;

	typedef struct packed {
		logic               stop_mode;
		logic [COLOR_W-1:0] color_start;
		logic [COLOR_W-1:0] color_mid;
		logic [COLOR_W-1:0] color_end;
		logic [VALUE_W-1:0] range_low;
		logic [VALUE_W-1:0] range_high;
	} cfg_t;

	// idx 0 = red (top channel), 1 = green, 2 = blue
	function automatic logic [CHANNEL_BITS-1:0] get_chan(input logic [COLOR_W-1:0] color,
		input int idx);
		get_chan = color[(2 - idx) * CHANNEL_BITS +: CHANNEL_BITS];
	endfunction

endpackage
`default_nettype wire

>>> design/scr_front.sv
`default_nettype none
module scr_front import scr_pkg::*; (
	input  logic [VALUE_W-1:0] value,
	input  cfg_t               cfg,
	output entry_t             entry
);

	logic below;
	logic above;

	always_comb begin
		below = $signed(value) < $signed(cfg.range_low);
		above = !below && ($signed(value) >= $signed(cfg.range_high));
		if (below) begin
			entry.cls = CLS_BELOW;
		end else if (above) begin
			entry.cls = CLS_ABOVE;
		end else begin
			entry.cls = CLS_INSIDE;
		end
		entry.off  = value - cfg.range_low;
		entry.span = cfg.range_high - cfg.range_low;
	end

endmodule
`default_nettype wire

>>> design/scr_queue.sv
`default_nettype none
module scr_queue import scr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

>>> design/scr_divider.sv
`default_nettype none
module scr_divider import scr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  entry_t                   in_entry,
	output logic                     out_valid,
	output cls_t                     out_cls,
	output logic [FRACTION_BITS-1:0] out_quot
);

	localparam int STAGES = FRACTION_BITS;

	// restoring division, one quotient bit per stage
	logic [STAGES-1:0]        v_s;
	cls_t                     cls_s  [STAGES];
	logic [VALUE_W-1:0]       rem_s  [STAGES];
	logic [VALUE_W-1:0]       dvs_s  [STAGES];
	logic [FRACTION_BITS-1:0] quot_s [STAGES];

	cls_t                     cls_in  [STAGES];
	logic [VALUE_W-1:0]       rem_in  [STAGES];
	logic [VALUE_W-1:0]       dvs_in  [STAGES];
	logic [FRACTION_BITS-1:0] quot_in [STAGES];
	logic [VALUE_W:0]         shifted [STAGES];
	logic [VALUE_W:0]         trial   [STAGES];
	logic [VALUE_W-1:0]       rem_nx  [STAGES];
	logic [FRACTION_BITS-1:0] quot_nx [STAGES];

	always_comb begin
		for (int k = 0; k < STAGES; k++) begin
			if (k == 0) begin
				cls_in[k]  = in_entry.cls;
				rem_in[k]  = in_entry.off;
				dvs_in[k]  = in_entry.span;
				quot_in[k] = '0;
			end else begin
				cls_in[k]  = cls_s[k-1];
				rem_in[k]  = rem_s[k-1];
				dvs_in[k]  = dvs_s[k-1];
				quot_in[k] = quot_s[k-1];
			end
			shifted[k] = {rem_in[k], 1'b0};
			trial[k]   = shifted[k] - {1'b0, dvs_in[k]};
			if (shifted[k] >= {1'b0, dvs_in[k]}) begin
				rem_nx[k]  = trial[k][VALUE_W-1:0];
				quot_nx[k] = {quot_in[k][FRACTION_BITS-2:0], 1'b1};
			end else begin
				rem_nx[k]  = shifted[k][VALUE_W-1:0];
				quot_nx[k] = {quot_in[k][FRACTION_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STAGES; k++) begin
				cls_s[k]  <= cls_in[k];
				rem_s[k]  <= rem_nx[k];
				dvs_s[k]  <= dvs_in[k];
				quot_s[k] <= quot_nx[k];
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_cls   = cls_s[STAGES-1];
	assign out_quot  = quot_s[STAGES-1];

endmodule
`default_nettype wire

>>> design/scr_back.sv
`default_nettype none
module scr_back import scr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	input  cls_t                     in_cls,
	input  logic [FRACTION_BITS-1:0] in_quot,
	input  logic                     pop,
	output logic                     en,
	output logic                     empty,
	output logic [CHANNEL_BITS-1:0]  red,
	output logic [CHANNEL_BITS-1:0]  green,
	output logic [CHANNEL_BITS-1:0]  blue
);

	localparam int PROD_W = FRACTION_BITS + CHANNEL_BITS + 2;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);

	logic [CHANNEL_BITS-1:0]        a_sel  [3];
	logic [CHANNEL_BITS-1:0]        b_sel  [3];
	logic [FRACTION_BITS-1:0]       g_sel;
	logic signed [CHANNEL_BITS:0]   diff   [3];
	logic signed [PROD_W-1:0]       prod   [3];
	logic signed [PROD_W-1:0]       sum    [3];
	logic [CHANNEL_BITS-1:0]        chan_o [3];

	logic                           v_s1;
	logic [CHANNEL_BITS-1:0]        a_s1    [3];
	logic signed [PROD_W-1:0]       prod_s1 [3];

	logic                           out_v_q;
	logic [CHANNEL_BITS-1:0]        red_q;
	logic [CHANNEL_BITS-1:0]        green_q;
	logic [CHANNEL_BITS-1:0]        blue_q;

	assign en    = !out_v_q || pop;
	assign empty = !out_v_q;

	// stage 1: segment select and multiply
	always_comb begin
		g_sel = '0;
		for (int c = 0; c < 3; c++) begin
			a_sel[c] = get_chan(cfg.color_start, c);
			b_sel[c] = get_chan(cfg.color_start, c);
		end
		case (in_cls)
			CLS_BELOW: begin
				g_sel = '0;
			end
			CLS_ABOVE: begin
				for (int c = 0; c < 3; c++) begin
					a_sel[c] = get_chan(cfg.color_end, c);
					b_sel[c] = get_chan(cfg.color_end, c);
				end
			end
			CLS_INSIDE: begin
				if (!cfg.stop_mode) begin
					g_sel = in_quot;
					for (int c = 0; c < 3; c++) begin
						b_sel[c] = get_chan(cfg.color_end, c);
					end
				end else if (!in_quot[FRACTION_BITS-1]) begin
					g_sel = {in_quot[FRACTION_BITS-2:0], 1'b0};
					for (int c = 0; c < 3; c++) begin
						b_sel[c] = get_chan(cfg.color_mid, c);
					end
				end else begin
					// 2f - 1: the top bit drops out of the doubled fraction
					g_sel = {in_quot[FRACTION_BITS-2:0], 1'b0};
					for (int c = 0; c < 3; c++) begin
						a_sel[c] = get_chan(cfg.color_mid, c);
						b_sel[c] = get_chan(cfg.color_end, c);
					end
				end
			end
			default: begin
				g_sel = '0;
			end
		endcase
		for (int c = 0; c < 3; c++) begin
			diff[c] = $signed({1'b0, b_sel[c]}) - $signed({1'b0, a_sel[c]});
			prod[c] = PROD_W'($signed({1'b0, g_sel})) * PROD_W'(diff[c]);
		end
	end

	// stage 2: offset, round and clamp
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = $signed({2'b00, a_s1[c], {FRACTION_BITS{1'b0}}}) + prod_s1[c]
				+ $signed(ROUND_HALF);
			if (sum[c][PROD_W-1]) begin
				chan_o[c] = '0;
			end else begin
				chan_o[c] = sum[c][FRACTION_BITS +: CHANNEL_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				a_s1[c]    <= a_sel[c];
				prod_s1[c] <= prod[c];
			end
			red_q   <= chan_o[0];
			green_q <= chan_o[1];
			blue_q  <= chan_o[2];
		end
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule
`default_nettype wire

>>> design/scalar_to_color_ramp_unit.sv
// Scalar to colour ramp unit.
// Input queue port: value is taken at a rising edge with push high and full low.
// Result queue port: red/green/blue are valid while empty is low; the
// transaction completes at a rising edge with pop high and empty low.
// Configuration: cfg_index/cfg_data written when cfg_valid is high; cfg_ready
// is always high. Write only while no transaction is in flight.
// Path: an input transaction passes through the front queue, 16 divider stages
// at one quotient bit each and the multiply stage, after which the output
// register presents it. Throughput: one transaction per cycle while results
// are popped, set by the pipelined divider and the single-entry output register.
// Stall: while a result waits unpopped the back end holds; the 4-entry front
// queue absorbs further input, then full rises.
// Reset: queue and pipeline empty, registers at their reset colours and range.
`default_nettype none
module scalar_to_color_ramp_unit import scr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [VALUE_W-1:0]      value,
	output logic                    empty,
	input  logic                    pop,
	output logic [CHANNEL_BITS-1:0] red,
	output logic [CHANNEL_BITS-1:0] green,
	output logic [CHANNEL_BITS-1:0] blue,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t                     cfg_q;
	entry_t                   front_entry;
	entry_t                   q_head;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_pop;
	logic                     back_en;
	logic                     div_valid;
	cls_t                     div_cls;
	logic [FRACTION_BITS-1:0] div_quot;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign q_pop     = back_en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_mode   <= 1'b0;
			cfg_q.color_start <= '0;
			cfg_q.color_mid   <= MID_RESET;
			cfg_q.color_end   <= END_RESET;
			cfg_q.range_low   <= '0;
			cfg_q.range_high  <= HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STOP_MODE:   cfg_q.stop_mode   <= cfg_data[0];
				REG_COLOR_START: cfg_q.color_start <= cfg_data[COLOR_W-1:0];
				REG_COLOR_MID:   cfg_q.color_mid   <= cfg_data[COLOR_W-1:0];
				REG_COLOR_END:   cfg_q.color_end   <= cfg_data[COLOR_W-1:0];
				REG_RANGE_LOW:   cfg_q.range_low   <= cfg_data[VALUE_W-1:0];
				REG_RANGE_HIGH:  cfg_q.range_high  <= cfg_data[VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	scr_front u_front (
		.value (value),
		.cfg   (cfg_q),
		.entry (front_entry)
	);

	scr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push && !q_full),
		.push_entry (front_entry),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	scr_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (!q_empty),
		.in_entry  (q_head),
		.out_valid (div_valid),
		.out_cls   (div_cls),
		.out_quot  (div_quot)
	);

	scr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (div_valid),
		.in_cls   (div_cls),
		.in_quot  (div_quot),
		.pop      (pop),
		.en       (back_en),
		.empty    (empty),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("front queue full and empty together");

	a_stall_holds_div: assert property (@(posedge clk) disable iff (!arst_n)
		!back_en |=> $stable(div_valid) && (!div_valid || $stable(div_quot)))
		else $error("divider moved while back end stalled");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty && $stable(red) && $stable(green) && $stable(blue))
		else $error("waiting result changed before it was taken");

	a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |-> !q_pop)
		else $error("front queue drained while result stalled");

endmodule
`default_nettype wire
